// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers shared by the chunk walker modules
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

// ===== hw/rtl/rcw_pkg.sv =====
// ----------------------------------------------------------------------------
// rcw_pkg
// shared types and constants of the riff chunk walker
// ----------------------------------------------------------------------------
`default_nettype none

package rcw_pkg;

	// nesting limit default
	localparam int MAX_DEPTH_DEF = 8;

	// command queue between parser and level tracker
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

	// tags, first character in the low byte
	localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
	localparam logic [31:0] TAG_LIST = 32'h5453_494C;

	// list contents start after the four-byte list type
	localparam logic [31:0] LIST_TYPE_LEN = 32'd4;
	localparam logic [31:0] POS_MAX       = 32'hFFFF_FFFF;

	typedef enum logic [1:0] {
		EV_LEAF  = 2'd0,
		EV_OPEN  = 2'd1,
		EV_CLOSE = 2'd2,
		EV_ERROR = 2'd3
	} event_kind_t;

	typedef enum logic [1:0] {
		PH_TAG     = 2'd0,
		PH_SIZE    = 2'd1,
		PH_TYPE    = 2'd2,
		PH_PAYLOAD = 2'd3
	} parse_phase_t;

	typedef enum logic [1:0] {
		CMD_LEAF  = 2'd0,
		CMD_LIST  = 2'd1,
		CMD_CHECK = 2'd2
	} cmd_kind_t;

	typedef enum logic {
		BK_IDLE  = 1'b0,
		BK_CLOSE = 1'b1
	} back_state_t;

	// one parsed header or close check
	typedef struct packed {
		cmd_kind_t   kind;
		logic [31:0] tag;
		logic [31:0] pos;
		logic [31:0] size;
	} cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rcw_front.sv =====
// ----------------------------------------------------------------------------
// rcw_front
// byte parser: collects tags and sizes, skips payload, posts commands
// ----------------------------------------------------------------------------
`default_nettype none

module rcw_front (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               accept,
	input  wire  [7:0]        data_byte,
	output logic              push,
	output rcw_pkg::cmd_t     cmd
);

	rcw_pkg::parse_phase_t phase_q, phase_d;
	logic [1:0]  idx_q, idx_d;
	logic [31:0] tag_q, tag_d;
	logic [31:0] size_q, size_d;
	logic [31:0] left_q, left_d;
	logic [31:0] pos_q, pos_d;
	logic [31:0] tag_sh;
	logic [31:0] size_sh;

	assign tag_sh  = {data_byte, tag_q[31:8]};
	assign size_sh = {data_byte, size_q[31:8]};

	always_comb begin
		phase_d  = phase_q;
		idx_d    = idx_q;
		tag_d    = tag_q;
		size_d   = size_q;
		left_d   = left_q;
		pos_d    = pos_q;
		push     = 1'b0;
		cmd.kind = rcw_pkg::CMD_CHECK;
		cmd.tag  = tag_q;
		cmd.pos  = pos_d;
		cmd.size = size_q;
		if (accept) begin
			// saturating byte count
			pos_d   = (pos_q == rcw_pkg::POS_MAX) ? rcw_pkg::POS_MAX : pos_q + 32'd1;
			cmd.pos = pos_d;
			unique case (phase_q)
				rcw_pkg::PH_TAG: begin
					tag_d = tag_sh;
					idx_d = idx_q + 2'd1;
					if (idx_q == 2'd3) begin
						phase_d = rcw_pkg::PH_SIZE;
						size_d  = '0;
					end
				end
				rcw_pkg::PH_SIZE: begin
					size_d = size_sh;
					idx_d  = idx_q + 2'd1;
					if (idx_q == 2'd3) begin
						if (tag_q == rcw_pkg::TAG_RIFF || tag_q == rcw_pkg::TAG_LIST) begin
							phase_d = rcw_pkg::PH_TYPE;
							tag_d   = '0;
						end else begin
							push     = 1'b1;
							cmd.kind = rcw_pkg::CMD_LEAF;
							cmd.size = size_sh;
							if (size_sh != '0) begin
								phase_d = rcw_pkg::PH_PAYLOAD;
								left_d  = size_sh;
							end else begin
								phase_d = rcw_pkg::PH_TAG;
							end
						end
					end
				end
				rcw_pkg::PH_TYPE: begin
					tag_d = tag_sh;
					idx_d = idx_q + 2'd1;
					if (idx_q == 2'd3) begin
						push     = 1'b1;
						cmd.kind = rcw_pkg::CMD_LIST;
						cmd.tag  = tag_sh;
						phase_d  = rcw_pkg::PH_TAG;
					end
				end
				rcw_pkg::PH_PAYLOAD: begin
					left_d = left_q - 32'd1;
					if (left_q == 32'd1) begin
						push    = 1'b1;
						phase_d = rcw_pkg::PH_TAG;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= rcw_pkg::PH_TAG;
			idx_q   <= '0;
			tag_q   <= '0;
			size_q  <= '0;
			left_q  <= '0;
			pos_q   <= '0;
		end else begin
			phase_q <= phase_d;
			idx_q   <= idx_d;
			tag_q   <= tag_d;
			size_q  <= size_d;
			left_q  <= left_d;
			pos_q   <= pos_d;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/rcw_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// rcw_cmd_fifo
// short command queue between the byte parser and the level tracker
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module rcw_cmd_fifo (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               push,
	input  rcw_pkg::cmd_t     wr_cmd,
	input  wire               pop,
	output rcw_pkg::cmd_t     rd_cmd,
	output logic              full,
	output logic              empty
);

	localparam int PW = rcw_pkg::FIFO_PTR_W;

	rcw_pkg::cmd_t mem_q [rcw_pkg::FIFO_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW:0]   count_q;

	assign full   = (count_q == (PW+1)'(rcw_pkg::FIFO_DEPTH));
	assign empty  = (count_q == '0);
	assign rd_cmd = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(rcw_pkg::FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(rcw_pkg::FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`ASSERT_NEVER(a_push_full, clk, arst_n, push && full, "command queue overflow")
	`ASSERT_NEVER(a_pop_empty, clk, arst_n, pop && empty, "command queue underflow")
	`ASSERT_PROP(a_count_range, clk, arst_n, count_q <= (PW+1)'(rcw_pkg::FIFO_DEPTH), "queue count out of range")

endmodule

`default_nettype wire

// ===== hw/rtl/rcw_back.sv =====
// ----------------------------------------------------------------------------
// rcw_back
// level tracker: keeps the open list stack and emits events in order
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module rcw_back #(
	parameter int MAX_DEPTH = rcw_pkg::MAX_DEPTH_DEF
) (
	input  wire               clk,
	input  wire               arst_n,
	input  rcw_pkg::cmd_t     head,
	input  wire               head_valid,
	output logic              pop,
	output logic              event_valid,
	input  wire               event_stall,
	output logic [1:0]        event_kind,
	output logic [31:0]       chunk_tag,
	output logic [3:0]        nest_depth,
	output logic [31:0]       data_offset,
	output logic [31:0]       chunk_size,
	output logic              last_event
);

	localparam int CNT_W = $clog2(MAX_DEPTH + 1);
	localparam int IDX_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

	rcw_pkg::back_state_t state_q, state_d;
	logic [CNT_W-1:0] open_q, open_d;
	logic [CNT_W-1:0] open_m1, open_m2;
	logic             done_q, done_d;
	logic [31:0]      pos_q, pos_d;
	logic [31:0]      lvl_end_q  [MAX_DEPTH];
	logic [31:0]      lvl_type_q [MAX_DEPTH];
	logic [31:0]      cmp_pos;
	logic [MAX_DEPTH-1:0] hit;
	logic             top_hit, below_hit;
	logic             out_free;

	// new level end
	logic [31:0] list_len;
	logic [32:0] end_sum;
	logic [31:0] new_end;
	logic        wr_en;

	// output register load
	logic             ld;
	rcw_pkg::event_kind_t ld_kind;
	logic [31:0]      ld_tag, ld_off, ld_size;
	logic [CNT_W-1:0] ld_depth;
	logic [CNT_W+3:0] depth_ext;
	logic             ld_last;

	logic             ev_valid_q, ev_last_q;
	logic [1:0]       ev_kind_q;
	logic [31:0]      ev_tag_q, ev_off_q, ev_size_q;
	logic [3:0]       ev_depth_q;

	assign out_free = !ev_valid_q || !event_stall;
	assign cmp_pos  = (state_q == rcw_pkg::BK_IDLE) ? head.pos : pos_q;
	assign open_m1  = open_q - 1'b1;
	assign open_m2  = open_q - 2'd2;

	// one end compare per level
	always_comb begin
		for (int i = 0; i < MAX_DEPTH; i++) begin
			hit[i] = (lvl_end_q[i] <= cmp_pos);
		end
	end

	assign top_hit   = (open_q != '0) && hit[open_m1[IDX_W-1:0]];
	assign below_hit = (open_q > CNT_W'(1)) && hit[open_m2[IDX_W-1:0]];

	assign list_len  = (head.size > rcw_pkg::LIST_TYPE_LEN) ?
	                   head.size - rcw_pkg::LIST_TYPE_LEN : '0;
	assign end_sum   = {1'b0, head.pos} + {1'b0, list_len};
	assign new_end   = end_sum[32] ? rcw_pkg::POS_MAX : end_sum[31:0];

	always_comb begin
		state_d  = state_q;
		open_d   = open_q;
		done_d   = done_q;
		pos_d    = pos_q;
		pop      = 1'b0;
		wr_en    = 1'b0;
		ld       = 1'b0;
		ld_kind  = rcw_pkg::EV_LEAF;
		ld_tag   = head.tag;
		ld_depth = open_q;
		ld_off   = head.pos;
		ld_size  = head.size;
		ld_last  = 1'b1;
		unique case (state_q)
			rcw_pkg::BK_IDLE: begin
				if (head_valid && out_free) begin
					pop   = 1'b1;
					pos_d = head.pos;
					if (!done_q) begin
						unique case (head.kind)
							rcw_pkg::CMD_LEAF: begin
								ld = 1'b1;
								if (open_q == '0) begin
									ld_kind = rcw_pkg::EV_ERROR;
									done_d  = 1'b1;
								end else if (head.size == '0 && top_hit) begin
									ld_last = 1'b0;
									state_d = rcw_pkg::BK_CLOSE;
								end
							end
							rcw_pkg::CMD_LIST: begin
								ld = 1'b1;
								if (open_q >= CNT_W'(MAX_DEPTH)) begin
									ld_kind = rcw_pkg::EV_ERROR;
									done_d  = 1'b1;
								end else begin
									wr_en   = 1'b1;
									ld_kind = rcw_pkg::EV_OPEN;
									open_d  = open_q + 1'b1;
									// empty list, or position already saturated
									if (head.size <= rcw_pkg::LIST_TYPE_LEN ||
									    head.pos == rcw_pkg::POS_MAX) begin
										ld_last = 1'b0;
										state_d = rcw_pkg::BK_CLOSE;
									end
								end
							end
							rcw_pkg::CMD_CHECK: begin
								if (top_hit) begin
									state_d = rcw_pkg::BK_CLOSE;
								end
							end
							default: ;
						endcase
					end
				end
			end
			rcw_pkg::BK_CLOSE: begin
				if (out_free) begin
					ld       = 1'b1;
					ld_kind  = rcw_pkg::EV_CLOSE;
					ld_tag   = lvl_type_q[open_m1[IDX_W-1:0]];
					ld_depth = open_m1;
					ld_off   = '0;
					ld_size  = '0;
					ld_last  = !below_hit;
					open_d   = open_m1;
					if (open_m1 == '0) begin
						done_d = 1'b1;
					end
					if (!below_hit) begin
						state_d = rcw_pkg::BK_IDLE;
					end
				end
			end
			default: ;
		endcase
	end

	assign depth_ext = {4'b0, ld_depth};

	always_ff @(posedge clk) begin
		if (wr_en) begin
			lvl_end_q[open_q[IDX_W-1:0]]  <= new_end;
			lvl_type_q[open_q[IDX_W-1:0]] <= head.tag;
		end
		if (ld) begin
			ev_kind_q  <= ld_kind;
			ev_tag_q   <= ld_tag;
			ev_depth_q <= depth_ext[3:0];
			ev_off_q   <= ld_off;
			ev_size_q  <= ld_size;
			ev_last_q  <= ld_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= rcw_pkg::BK_IDLE;
			open_q     <= '0;
			done_q     <= 1'b0;
			pos_q      <= '0;
			ev_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			open_q  <= open_d;
			done_q  <= done_d;
			pos_q   <= pos_d;
			if (ld) begin
				ev_valid_q <= 1'b1;
			end else if (!event_stall) begin
				ev_valid_q <= 1'b0;
			end
		end
	end

	assign event_valid = ev_valid_q;
	assign event_kind  = ev_kind_q;
	assign chunk_tag   = ev_tag_q;
	assign nest_depth  = ev_depth_q;
	assign data_offset = ev_off_q;
	assign chunk_size  = ev_size_q;
	assign last_event  = ev_last_q;

	`ASSERT_PROP(a_done_sticky, clk, arst_n, done_q |=> done_q, "walk end flag dropped")
	`ASSERT_NEVER(a_event_after_done, clk, arst_n, done_q && ld, "event after walk end")
	`ASSERT_NEVER(a_close_no_level, clk, arst_n, (state_q == rcw_pkg::BK_CLOSE) && (open_q == '0), "close with no open level")
	`ASSERT_PROP(a_depth_range, clk, arst_n, open_q <= CNT_W'(MAX_DEPTH), "open level count over limit")

endmodule

`default_nettype wire

// ===== hw/rtl/riff_chunk_walker.sv =====
// ----------------------------------------------------------------------------
// riff_chunk_walker
// byte-serial RIFF container walker reporting leaf, open, close and error
// ----------------------------------------------------------------------------
// The file enters one byte per word on the byte channel and the walker emits
// one event per word on the event channel. A byte is taken in every cycle as
// long as the four-entry command queue between the parser and the level
// tracker has room; most header bytes and payload bytes other than the last
// cause no command. The level tracker retires one event per cycle unless
// event_stall holds it: a header byte causes up to MAX_DEPTH + 1 events, and
// a payload end costs it a check plus one close event per list it closes.
// last_event marks the final event of each byte. Close events carry zero
// offset and size. After an error, or once the outermost list closes, bytes
// are still taken but ignored. No clearing pass runs after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module riff_chunk_walker #(
	parameter int MAX_DEPTH = rcw_pkg::MAX_DEPTH_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	// byte channel
	input  wire         byte_valid,
	output logic        byte_stall,
	input  wire  [7:0]  data_byte,
	// event channel
	output logic        event_valid,
	input  wire         event_stall,
	output logic [1:0]  event_kind,
	output logic [31:0] chunk_tag,
	output logic [3:0]  nest_depth,
	output logic [31:0] data_offset,
	output logic [31:0] chunk_size,
	output logic        last_event
);

	logic          accept;
	logic          push, pop;
	logic          full, empty;
	rcw_pkg::cmd_t front_cmd;
	rcw_pkg::cmd_t head_cmd;

	// queue full is the only backpressure on the byte side
	assign byte_stall = full;
	assign accept     = byte_valid && !full;

	// front: tag, size and list type assembly, payload skip
	rcw_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.data_byte (data_byte),
		.push      (push),
		.cmd       (front_cmd)
	);

	// decoupling queue
	rcw_cmd_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_cmd (front_cmd),
		.pop    (pop),
		.rd_cmd (head_cmd),
		.full   (full),
		.empty  (empty)
	);

	// back: level stack, close cascade, output register
	rcw_back #(
		.MAX_DEPTH (MAX_DEPTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head_cmd),
		.head_valid  (!empty),
		.pop         (pop),
		.event_valid (event_valid),
		.event_stall (event_stall),
		.event_kind  (event_kind),
		.chunk_tag   (chunk_tag),
		.nest_depth  (nest_depth),
		.data_offset (data_offset),
		.chunk_size  (chunk_size),
		.last_event  (last_event)
	);

endmodule

`default_nettype wire

// ===== sim/riff_chunk_walker_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// riff_chunk_walker_test
// self-checking bench for the byte-serial riff chunk walker
// ----------------------------------------------------------------------------
// A RIFF image is built before reset. It starts with a short hand-written
// header table, then a random body of leaf chunks and nested lists, then a
// chain of lists deep enough to trip the nesting error, then a few bytes that
// arrive after the walk is over. Every byte word taken by the walker runs
// through a local parser model that queues the events it should cause. Every
// event word is compared field by field with the oldest queued event. Both
// channels idle at random, with quiet stretches between.
// ----------------------------------------------------------------------------

module riff_chunk_walker_test;

	localparam int WALK_DEPTH   = rcw_pkg::MAX_DEPTH_DEF;
	localparam int INTRO_LEN    = 24;
	localparam int BODY_BYTES   = 206;      // random body stops growing here
	localparam int DRAIN_CYCLES = 40;       // quiet time after the last event
	localparam int LIMIT_CYCLES = 400_000;

	// one event word as the walker reports it
	typedef struct packed {
		rcw_pkg::event_kind_t kind;
		logic [31:0] tag;
		logic [3:0]  depth;
		logic [31:0] data_start;
		logic [31:0] declared;
		logic        last;
	} event_rec_t;

	// one row of the hand-written header table
	typedef struct packed {
		logic [7:0] data;
		logic       typed;              // row carries its own expected event
		event_rec_t ev;
	} stim_row_t;

	localparam event_rec_t NO_EVENT = '0;

	// ------------------------------------------------------------------
	// clock, reset and dut ports
	// ------------------------------------------------------------------
	logic        clk;
	logic        arst_n      = 1'b0;
	logic        byte_valid  = 1'b0;
	logic        byte_stall;
	logic [7:0]  data_byte   = 8'h00;
	logic        event_valid;
	logic        event_stall = 1'b0;
	logic [1:0]  event_kind;
	logic [31:0] chunk_tag;
	logic [3:0]  nest_depth;
	logic [31:0] data_offset;
	logic [31:0] chunk_size;
	logic        last_event;

	riff_chunk_walker #(
		.MAX_DEPTH (WALK_DEPTH)
	) DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_valid  (byte_valid),
		.byte_stall  (byte_stall),
		.data_byte   (data_byte),
		.event_valid (event_valid),
		.event_stall (event_stall),
		.event_kind  (event_kind),
		.chunk_tag   (chunk_tag),
		.nest_depth  (nest_depth),
		.data_offset (data_offset),
		.chunk_size  (chunk_size),
		.last_event  (last_event)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// hand-written file head
	// outer RIFF with size all ones, so its end position saturates and it
	// never closes; then a LIST whose size is below four, which opens and
	// closes on its last type byte; byte values 00 and ff both appear
	// ------------------------------------------------------------------
	stim_row_t intro_rows [INTRO_LEN] = '{
		'{8'h52, 1'b0, NO_EVENT},       // "RIFF"
		'{8'h49, 1'b0, NO_EVENT},
		'{8'h46, 1'b0, NO_EVENT},
		'{8'h46, 1'b0, NO_EVENT},
		'{8'hFF, 1'b0, NO_EVENT},       // size 0xffffffff
		'{8'hFF, 1'b0, NO_EVENT},
		'{8'hFF, 1'b0, NO_EVENT},
		'{8'hFF, 1'b0, NO_EVENT},
		'{8'h57, 1'b0, NO_EVENT},       // list type "WAVE"
		'{8'h41, 1'b0, NO_EVENT},
		'{8'h56, 1'b0, NO_EVENT},
		'{8'h45, 1'b1,
			'{rcw_pkg::EV_OPEN, 32'h4556_4157, 4'd0, 32'd12, 32'hFFFF_FFFF, 1'b1}},
		'{8'h4C, 1'b0, NO_EVENT},       // "LIST"
		'{8'h49, 1'b0, NO_EVENT},
		'{8'h53, 1'b0, NO_EVENT},
		'{8'h54, 1'b0, NO_EVENT},
		'{8'h01, 1'b0, NO_EVENT},       // size 1, below the type length
		'{8'h00, 1'b0, NO_EVENT},
		'{8'h00, 1'b0, NO_EVENT},
		'{8'h00, 1'b0, NO_EVENT},
		'{8'hFF, 1'b0, NO_EVENT},       // list type, open then close at once
		'{8'h00, 1'b0, NO_EVENT},
		'{8'h80, 1'b0, NO_EVENT},
		'{8'h7F, 1'b0, NO_EVENT}
	};

	// ------------------------------------------------------------------
	// file image builder
	// ------------------------------------------------------------------
	logic [7:0] file_bytes [$];

	// little-endian, low byte first, which is also tag character order
	function automatic void push_word(logic [31:0] w);
		for (int k = 0; k < 4; k++)
			file_bytes.insert(file_bytes.size(), w[8*k +: 8]);
	endfunction

	// write the size of a list once its contents are known
	function automatic void close_gen_list(int size_at, int body_start);
		int          body_len;
		logic [31:0] sz;
		body_len = file_bytes.size() - body_start;
		if (body_len == 0)
			sz = 32'($urandom_range(0, 4));                 // empty, size may be under four
		else if ($urandom_range(0, 4) == 0)
			sz = 32'(body_len + 4) - 32'($urandom_range(1, body_len));  // child overruns
		else
			sz = 32'(body_len + 4);
		for (int k = 0; k < 4; k++)
			file_bytes[size_at + k] = sz[8*k +: 8];
	endfunction

	function automatic void build_file();
		int          gen_depth;
		int          size_at [WALK_DEPTH];
		int          body_at [WALK_DEPTH];
		int          pick;
		int          leaf_len;
		logic [31:0] leaf_tag;
		foreach (intro_rows[i])
			file_bytes.insert(file_bytes.size(), intro_rows[i].data);
		gen_depth = 1;                  // inside the outer RIFF
		// random body, kept one level short of the nesting limit
		while (file_bytes.size() < BODY_BYTES) begin
			pick = $urandom_range(0, 99);
			if (pick >= 60 && pick < 82 && gen_depth < WALK_DEPTH - 1) begin
				push_word(($urandom_range(0, 4) == 0) ? rcw_pkg::TAG_RIFF : rcw_pkg::TAG_LIST);
				size_at[gen_depth] = file_bytes.size();
				push_word('0);          // patched at close
				push_word($urandom);
				body_at[gen_depth] = file_bytes.size();
				gen_depth++;
			end else if (pick >= 82 && gen_depth > 1) begin
				gen_depth--;
				close_gen_list(size_at[gen_depth], body_at[gen_depth]);
			end else begin
				// leaf: any tag but the two list tags, mostly short payload
				do
					leaf_tag = $urandom;
				while (leaf_tag == rcw_pkg::TAG_RIFF || leaf_tag == rcw_pkg::TAG_LIST);
				push_word(leaf_tag);
				pick = $urandom_range(0, 19);
				if (pick < 6)
					leaf_len = 0;
				else if (pick == 19)
					leaf_len = $urandom_range(13, 40);
				else
					leaf_len = $urandom_range(1, 12);
				push_word(32'(leaf_len));
				repeat (leaf_len)
					file_bytes.insert(file_bytes.size(), 8'($urandom));
			end
		end
		while (gen_depth > 1) begin
			gen_depth--;
			close_gen_list(size_at[gen_depth], body_at[gen_depth]);
		end
		// nesting chain with big sizes: the walker reaches its limit and
		// the next list is an error, after which all is ignored
		repeat (WALK_DEPTH + 1) begin
			push_word(($urandom_range(0, 1) == 0) ? rcw_pkg::TAG_RIFF : rcw_pkg::TAG_LIST);
			push_word(($urandom_range(0, 3) == 0) ? rcw_pkg::POS_MAX :
			          ($urandom | 32'h0001_0000));
			push_word($urandom);
		end
		repeat ($urandom_range(4, 12))
			file_bytes.insert(file_bytes.size(), 8'($urandom));
	endfunction

	// ------------------------------------------------------------------
	// parser model
	// ------------------------------------------------------------------
	logic [31:0]           pos_count  = '0;
	rcw_pkg::parse_phase_t phase      = rcw_pkg::PH_TAG;
	logic [1:0]            field_idx  = '0;
	logic [31:0]           tag_acc    = '0;
	logic [31:0]           size_acc   = '0;
	logic [31:0]           skip_left  = '0;
	logic [31:0]           lvl_end  [WALK_DEPTH];
	logic [31:0]           lvl_type [WALK_DEPTH];
	int                    depth_open = 0;
	logic                  walk_over  = 1'b0;

	event_rec_t   byte_events    [$];  // events of the byte being modeled
	event_rec_t   awaited_events [$];  // events still due from the walker

	function automatic void add_event(rcw_pkg::event_kind_t k, logic [31:0] tag, int depth,
			logic [31:0] data_start, logic [31:0] declared);
		event_rec_t ev;
		ev = '{k, tag, 4'(depth), data_start, declared, 1'b0};
		byte_events.insert(byte_events.size(), ev);
	endfunction

	// innermost first, while the position is at or past the level end
	function automatic void close_finished_levels(logic [31:0] pos);
		while (depth_open > 0 && lvl_end[depth_open - 1] <= pos) begin
			depth_open--;
			add_event(rcw_pkg::EV_CLOSE, lvl_type[depth_open], depth_open, '0, '0);
			if (depth_open == 0)
				walk_over = 1'b1;
		end
	endfunction

	function automatic void walk_byte(logic [7:0] b);
		logic [31:0] pos;
		logic [31:0] len;
		if (walk_over)
			return;
		pos = (pos_count == rcw_pkg::POS_MAX) ? rcw_pkg::POS_MAX : pos_count + 32'd1;
		pos_count = pos;
		case (phase)
			rcw_pkg::PH_TAG: begin
				tag_acc   = {b, tag_acc[31:8]};
				field_idx = field_idx + 2'd1;
				if (field_idx == 2'd0) begin
					phase    = rcw_pkg::PH_SIZE;
					size_acc = '0;
				end
			end
			rcw_pkg::PH_SIZE: begin
				size_acc  = {b, size_acc[31:8]};
				field_idx = field_idx + 2'd1;
				if (field_idx == 2'd0) begin
					if (tag_acc == rcw_pkg::TAG_RIFF || tag_acc == rcw_pkg::TAG_LIST) begin
						phase   = rcw_pkg::PH_TYPE;
						tag_acc = '0;
					end else if (depth_open == 0) begin
						// leaf with no list around it
						add_event(rcw_pkg::EV_ERROR, tag_acc, 0, pos, size_acc);
						walk_over = 1'b1;
					end else begin
						add_event(rcw_pkg::EV_LEAF, tag_acc, depth_open, pos, size_acc);
						if (size_acc != '0) begin
							phase     = rcw_pkg::PH_PAYLOAD;
							skip_left = size_acc;
						end else begin
							phase = rcw_pkg::PH_TAG;
							close_finished_levels(pos);
						end
					end
				end
			end
			rcw_pkg::PH_TYPE: begin
				tag_acc   = {b, tag_acc[31:8]};
				field_idx = field_idx + 2'd1;
				if (field_idx == 2'd0) begin
					if (depth_open >= WALK_DEPTH) begin
						add_event(rcw_pkg::EV_ERROR, tag_acc, depth_open, pos, size_acc);
						walk_over = 1'b1;
					end else begin
						len = (size_acc > rcw_pkg::LIST_TYPE_LEN) ?
						      size_acc - rcw_pkg::LIST_TYPE_LEN : '0;
						lvl_end[depth_open]  = (len > rcw_pkg::POS_MAX - pos) ?
						                       rcw_pkg::POS_MAX : pos + len;
						lvl_type[depth_open] = tag_acc;
						add_event(rcw_pkg::EV_OPEN, tag_acc, depth_open, pos, size_acc);
						depth_open++;
						phase = rcw_pkg::PH_TAG;
						close_finished_levels(pos);
					end
				end
			end
			default: begin
				if (skip_left != '0)
					skip_left = skip_left - 32'd1;
				if (skip_left == '0) begin
					phase = rcw_pkg::PH_TAG;
					close_finished_levels(pos);
				end
			end
		endcase
		if (byte_events.size() > 0)
			byte_events[byte_events.size() - 1].last = 1'b1;
	endfunction

	// ------------------------------------------------------------------
	// checking
	// ------------------------------------------------------------------
	int fault_count = 0;
	int bytes_taken = 0;
	int cycle_count = 0;

	function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", field, want, got);
			fault_count++;
		end
	endfunction

	// byte side first, so a byte's events are queued before any can show up
	always @(posedge clk) begin
		event_rec_t want;
		if (arst_n) begin
			if (byte_valid && !byte_stall) begin
				byte_events.delete();
				walk_byte(data_byte);
				if (bytes_taken < INTRO_LEN && intro_rows[bytes_taken].typed)
					awaited_events.insert(awaited_events.size(), intro_rows[bytes_taken].ev);
				else
					foreach (byte_events[i])
						awaited_events.insert(awaited_events.size(), byte_events[i]);
				bytes_taken++;
			end
			if (event_valid && !event_stall) begin
				if (awaited_events.size() == 0) begin
					$error("event_kind: expected no event, got %0d", event_kind);
					fault_count++;
				end else begin
					want = awaited_events[0];
					awaited_events.delete(0);
					check_field("event_kind",  32'(want.kind),  32'(event_kind));
					check_field("chunk_tag",   want.tag,        chunk_tag);
					check_field("nest_depth",  32'(want.depth), 32'(nest_depth));
					check_field("data_offset", want.data_start, data_offset);
					check_field("chunk_size",  want.declared,   chunk_size);
					check_field("last_event",  32'(want.last),  32'(last_event));
				end
			end
		end
	end

	// hard stop if the walker hangs
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("riff_chunk_walker_test: done, errors");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// idle pattern: half the words go straight through, the rest wait first;
	// now and then a quiet run with no waiting at all
	// ------------------------------------------------------------------
	function automatic int idle_cycles(inout int calm_left);
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		if ($urandom_range(0, 39) == 0) begin
			calm_left = $urandom_range(16, 48);
			return 0;
		end
		return ($urandom_range(0, 1) == 0) ? 0 : int'($urandom_range(1, 16));
	endfunction

	// event side back-pressure, held before each event word
	initial begin
		int stall_hold;
		int stall_calm;
		stall_calm = 0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			stall_hold = idle_cycles(stall_calm);
			if (stall_hold > 0) begin
				event_stall <= 1'b1;
				repeat (stall_hold) @(posedge clk);
			end
			event_stall <= 1'b0;
			@(posedge clk);
			while (!event_valid) @(posedge clk);
		end
	end

	// ------------------------------------------------------------------
	// reset, byte feed and end of run
	// ------------------------------------------------------------------
	initial begin
		int feed_gap;
		int feed_calm;
		feed_calm = 0;
		build_file();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (file_bytes[i]) begin
			feed_gap = idle_cycles(feed_calm);
			if (feed_gap > 0) begin
				byte_valid <= 1'b0;
				repeat (feed_gap) @(posedge clk);
			end
			byte_valid <= 1'b1;
			data_byte  <= file_bytes[i];
			@(posedge clk);
			while (byte_stall) @(posedge clk);
		end
		byte_valid <= 1'b0;
		// let the monitor see the last byte before looking at the queue
		@(posedge clk);
		while (awaited_events.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fault_count == 0 && awaited_events.size() == 0)
			$display("riff_chunk_walker_test: done, clean");
		else
			$display("riff_chunk_walker_test: done, errors");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/rcw_pkg.sv
hw/rtl/rcw_front.sv
hw/rtl/rcw_cmd_fifo.sv
hw/rtl/rcw_back.sv
hw/rtl/riff_chunk_walker.sv
sim/riff_chunk_walker_test.sv
